### hdl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Results that one input item can cause at most.
    localparam int MAX_RES = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    // Default depth of the queue between the decoder and the output stage.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    // Status codes of the closing result.
    localparam logic [1:0] ST_QUOTE    = 2'd0;
    localparam logic [1:0] ST_RAN_OUT  = 2'd1;
    localparam logic [1:0] ST_NO_QUOTE = 2'd2;

    // UTF-8 bounds and marks.
    localparam logic [15:0] UTF8_LIM1 = 16'h0080;
    localparam logic [15:0] UTF8_LIM2 = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_MASK  = 8'h3F;

    typedef enum logic [1:0] {
        M_IDLE,
        M_TEXT,
        M_ESC,
        M_HEX
    } t_mode;

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       done;
        logic [1:0] status;
    } t_result;

    // All results caused by one input item.
    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        t_result [MAX_RES-1:0]      res;
    } t_bundle;

    function automatic t_result mk_data(input logic [7:0] b);
        t_result r;
        r.data   = b;
        r.valid  = 1'b1;
        r.done   = 1'b0;
        r.status = ST_QUOTE;
        return r;
    endfunction

    function automatic t_result mk_done(input logic [1:0] st);
        t_result r;
        r.data   = 8'h00;
        r.valid  = 1'b0;
        r.done   = 1'b1;
        r.status = st;
        return r;
    endfunction

    // Map the character after a backslash to its decoded byte.
    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Value of a hex digit; meaningless for other characters.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if (c <= 8'h39) begin
            d = c - 8'h30;
        end else begin
            d = (c & 8'hDF) - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

### hdl/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [7:0]       i_in_byte,
    input  wire logic             i_first,
    input  wire logic             i_last,
    input  wire logic             i_full,
    output logic                  o_push,
    output jsu_pkg::t_bundle      o_bundle
);
    import jsu_pkg::*;

    t_mode       r_mode, n_mode;
    logic [15:0] r_hex_value, n_hex_value;
    logic [1:0]  r_hex_seen, n_hex_seen;
    logic        r_hex_open, n_hex_open;
    logic [7:0]  r_held [3];
    logic [7:0]  n_held [3];

    logic             accept;
    logic [CNT_W-1:0] cnt;
    t_result          res [MAX_RES];
    logic [7:0]       hx [4];
    logic [1:0]       tail_k;
    logic             skip;
    logic             stop;
    logic [15:0]      v;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    // Decode one byte into its list of results and the next state.
    always_comb begin
        n_mode      = r_mode;
        n_hex_value = r_hex_value;
        n_hex_seen  = r_hex_seen;
        n_hex_open  = r_hex_open;
        n_held      = r_held;
        cnt         = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '0;
        end
        hx     = '{8'h00, 8'h00, 8'h00, 8'h00};
        tail_k = 2'd0;
        skip   = 1'b0;
        stop   = 1'b0;
        v      = '0;

        if (i_first) begin
            // A new string drops any unicode escape that was in progress.
            n_hex_value = '0;
            n_hex_seen  = '0;
            n_hex_open  = 1'b1;
            if (i_in_byte != CH_QUOTE) begin
                res[cnt[IDX_W-1:0]] = mk_done(ST_NO_QUOTE);
                cnt    = cnt + 1'b1;
                n_mode = M_IDLE;
            end else begin
                n_mode = M_TEXT;
                if (i_last) begin
                    res[cnt[IDX_W-1:0]] = mk_done(ST_RAN_OUT);
                    cnt    = cnt + 1'b1;
                    n_mode = M_IDLE;
                end
            end
        end else begin
            unique case (r_mode)
                M_IDLE: begin
                end
                M_TEXT: begin
                    if (i_in_byte == CH_BSL) begin
                        if (i_last) begin
                            res[cnt[IDX_W-1:0]] = mk_data(i_in_byte);
                            cnt = cnt + 1'b1;
                            res[cnt[IDX_W-1:0]] = mk_done(ST_RAN_OUT);
                            cnt    = cnt + 1'b1;
                            n_mode = M_IDLE;
                        end else begin
                            n_mode = M_ESC;
                        end
                    end else if (i_in_byte == CH_QUOTE) begin
                        res[cnt[IDX_W-1:0]] = mk_done(ST_QUOTE);
                        cnt    = cnt + 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        res[cnt[IDX_W-1:0]] = mk_data(i_in_byte);
                        cnt = cnt + 1'b1;
                        if (i_last) begin
                            res[cnt[IDX_W-1:0]] = mk_done(ST_RAN_OUT);
                            cnt    = cnt + 1'b1;
                            n_mode = M_IDLE;
                        end
                    end
                end
                M_ESC: begin
                    if (i_in_byte == CH_U) begin
                        n_mode      = M_HEX;
                        n_hex_value = '0;
                        n_hex_seen  = '0;
                        n_hex_open  = 1'b1;
                    end else begin
                        res[cnt[IDX_W-1:0]] = mk_data(esc_map(i_in_byte));
                        cnt    = cnt + 1'b1;
                        n_mode = M_TEXT;
                    end
                    if (i_last) begin
                        res[cnt[IDX_W-1:0]] = mk_done(ST_RAN_OUT);
                        cnt    = cnt + 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_HEX: begin
                    // Hold the first three characters for a possible replay.
                    if (r_hex_seen != 2'd3) begin
                        n_held[r_hex_seen] = i_in_byte;
                    end
                    if (r_hex_open && is_hex(i_in_byte)) begin
                        n_hex_value = {r_hex_value[11:0], hex_val(i_in_byte)};
                    end else begin
                        n_hex_open = 1'b0;
                    end

                    if (r_hex_seen == 2'd3) begin
                        // Fourth character: emit the value as UTF-8.
                        v = n_hex_value;
                        if (is_hex(r_held[0])) begin
                            if (v < UTF8_LIM1) begin
                                res[cnt[IDX_W-1:0]] = mk_data(v[7:0]);
                                cnt = cnt + 1'b1;
                            end else if (v < UTF8_LIM2) begin
                                res[cnt[IDX_W-1:0]] = mk_data(UTF8_LEAD2 | {3'b000, v[10:6]});
                                cnt = cnt + 1'b1;
                                res[cnt[IDX_W-1:0]] = mk_data(UTF8_CONT | ({2'b00, v[5:0]}
                                                              & UTF8_MASK));
                                cnt = cnt + 1'b1;
                            end else begin
                                res[cnt[IDX_W-1:0]] = mk_data(UTF8_LEAD3 | {4'h0, v[15:12]});
                                cnt = cnt + 1'b1;
                                res[cnt[IDX_W-1:0]] = mk_data(UTF8_CONT | ({2'b00, v[11:6]}
                                                              & UTF8_MASK));
                                cnt = cnt + 1'b1;
                                res[cnt[IDX_W-1:0]] = mk_data(UTF8_CONT | ({2'b00, v[5:0]}
                                                              & UTF8_MASK));
                                cnt = cnt + 1'b1;
                            end
                        end
                        n_mode      = M_TEXT;
                        n_hex_value = '0;
                        n_hex_seen  = '0;
                        n_hex_open  = 1'b1;
                        if (i_last) begin
                            res[cnt[IDX_W-1:0]] = mk_done(ST_RAN_OUT);
                            cnt    = cnt + 1'b1;
                            n_mode = M_IDLE;
                        end
                    end else if (i_last) begin
                        // Input ended early: replay the held characters as text.
                        tail_k      = r_hex_seen + 2'd1;
                        n_hex_value = '0;
                        n_hex_seen  = '0;
                        n_hex_open  = 1'b1;
                        hx = '{n_held[0], n_held[1], n_held[2], 8'h00};
                        for (int p = 0; p < 3; p++) begin
                            if (skip) begin
                                skip = 1'b0;
                            end else if ((2'(p) < tail_k) && !stop) begin
                                if ((hx[p] == CH_BSL) && (3'(p + 1) < {1'b0, tail_k})) begin
                                    if (hx[p + 1] != CH_U) begin
                                        res[cnt[IDX_W-1:0]] = mk_data(esc_map(hx[p + 1]));
                                        cnt = cnt + 1'b1;
                                    end
                                    skip = 1'b1;
                                end else if (hx[p] == CH_QUOTE) begin
                                    res[cnt[IDX_W-1:0]] = mk_done(ST_QUOTE);
                                    cnt  = cnt + 1'b1;
                                    stop = 1'b1;
                                end else begin
                                    res[cnt[IDX_W-1:0]] = mk_data(hx[p]);
                                    cnt = cnt + 1'b1;
                                end
                            end
                        end
                        if (!stop) begin
                            res[cnt[IDX_W-1:0]] = mk_done(ST_RAN_OUT);
                            cnt = cnt + 1'b1;
                        end
                        n_mode = M_IDLE;
                    end else begin
                        n_hex_seen = r_hex_seen + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hand the results of the item to the queue.
    always_comb begin
        o_bundle.cnt = cnt;
        for (int i = 0; i < MAX_RES; i++) begin
            o_bundle.res[i] = res[i];
        end
    end
    assign o_push = accept && (cnt != '0);

    // Decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_hex_value <= '0;
            r_hex_seen  <= '0;
            r_hex_open  <= 1'b1;
        end else if (accept) begin
            r_mode      <= n_mode;
            r_hex_value <= n_hex_value;
            r_hex_seen  <= n_hex_seen;
            r_hex_open  <= n_hex_open;
        end
    end

    // Held characters need no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

    // A pushed item always carries one to four results.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_bundle.cnt != '0) && (o_bundle.cnt <= CNT_W'(MAX_RES)))
        else $error("jsu_front: bad result count");

    // The hex counter only advances while decoding a unicode escape.
    a_hex_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hex_seen != 2'd0) |-> (r_mode == M_HEX))
        else $error("jsu_front: hex count outside unicode escape");

endmodule

`default_nettype wire

### hdl/jsu_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  jsu_pkg::t_bundle      i_bundle,
    input  wire logic             i_pop,
    output jsu_pkg::t_bundle      o_head,
    output logic                  o_full,
    output logic                  o_empty
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    t_bundle             r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0]   r_fill, n_fill;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer and fill updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Storage for the queued items.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    // Neither overflow nor underflow may happen.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("jsu_queue: push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("jsu_queue: pop while empty");

endmodule

`default_nettype wire

### hdl/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  jsu_pkg::t_bundle      i_head,
    input  wire logic             i_empty,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_byte_valid,
    output logic                  o_done_res,
    output logic [1:0]            o_status
);
    import jsu_pkg::*;

    logic             r_valid;
    t_result          r_out;
    logic [IDX_W-1:0] r_idx;
    logic             load;
    logic             last_of_item;

    // Take the next result when the output register is free or being taken.
    assign load         = !i_empty && (!r_valid || !i_out_stall);
    assign last_of_item = (CNT_W'(r_idx) + 1'b1) == i_head.cnt;
    assign o_pop        = load && last_of_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= last_of_item ? '0 : r_idx + 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= i_head.res[r_idx];
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_out.data;
    assign o_byte_valid = r_out.valid;
    assign o_done_res   = r_out.done;
    assign o_status     = r_out.status;

    // A closing result never carries a byte, and a byte result has status zero.
    a_done_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_byte_valid)
        else $error("jsu_back: closing result carries a byte");

    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_byte_valid && (o_status == ST_QUOTE)))
        else $error("jsu_back: malformed byte result");

endmodule

`default_nettype wire

### hdl/json_string_unescaper.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Fields
// input     in         i_in_valid / o_in_stall    i_in_byte, i_first, i_last
// result    out        o_out_valid / i_out_stall  o_out_byte, o_byte_valid,
//                                                 o_done_res, o_status
//
// The decoder takes one byte per cycle while the result queue is not full and turns it
// into zero to four results. Each result leaves through the output register in a cycle
// of its own. Results are registered in the queue, then in the output register.
// Reset is synchronous and clears the decoder state, the queue and the output valid.
// The input stalls only while the result queue is full; the output side stalls the
// queue drain, and with it the input once the queue has filled.
module json_string_unescaper #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_first,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_done_res,
    output logic [1:0]       o_status
);
    import jsu_pkg::*;

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_bundle push_bundle;
    t_bundle head_bundle;

    // Byte decoder.
    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_byte  (i_in_byte),
        .i_first    (i_first),
        .i_last     (i_last),
        .i_full     (full),
        .o_push     (push),
        .o_bundle   (push_bundle)
    );

    // Queue of decoded result groups.
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_head   (head_bundle),
        .o_full   (full),
        .o_empty  (empty)
    );

    // Result serializer and output register.
    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_bundle),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_done_res   (o_done_res),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import jsu_pkg::*;

    // Cycles with no item accepted on either side before the run is abandoned.
    localparam int QUIET_LIMIT = 4000;
    // Counted input items in each random phase.
    localparam int PHASE_ITEMS = 135;
    // Cycles to watch for stray results once everything has arrived.
    localparam int TAIL_CYCLES = 12;

    typedef struct packed {
        logic [7:0] text;
        logic       first;
        logic       last;
    } t_text_item;

    // Decodes every accepted input byte and holds the results still owed by the block.
    class unescape_scoreboard;
        t_mode       mode;
        logic [15:0] code_point;
        logic [2:0]  digits_taken;
        bit          prefix_open;
        logic [7:0]  held [3];
        t_result     decoded_q [$];
        int unsigned errors;

        function new();
            mode         = M_IDLE;
            code_point   = 16'h0000;
            digits_taken = 3'd0;
            prefix_open  = 1'b1;
            errors       = 0;
            foreach (held[i]) held[i] = 8'h00;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void push_content(input logic [7:0] b);
            t_result r;
            r.data   = b;
            r.valid  = 1'b1;
            r.done   = 1'b0;
            r.status = ST_QUOTE;
            decoded_q.push_back(r);
        endfunction

        // The closing result of a string also returns the decoder to idle.
        function void push_done(input logic [1:0] st);
            t_result r;
            r.data   = 8'h00;
            r.valid  = 1'b0;
            r.done   = 1'b1;
            r.status = st;
            decoded_q.push_back(r);
            mode = M_IDLE;
        endfunction

        function void clear_hex();
            code_point   = 16'h0000;
            digits_taken = 3'd0;
            prefix_open  = 1'b1;
        endfunction

        function logic [7:0] unescape_char(input logic [7:0] c);
            case (c)
                "n":     return 8'h0A;
                "r":     return 8'h0D;
                "t":     return 8'h09;
                "b":     return 8'h08;
                "f":     return 8'h0C;
                default: return c;
            endcase
        endfunction

        function bit decode_hex_digit(input logic [7:0] c, output logic [3:0] nib);
            nib = 4'h0;
            if (c >= "0" && c <= "9") begin
                nib = 4'(c - "0");
                return 1'b1;
            end
            if (c >= "a" && c <= "f") begin
                nib = 4'(c - "a" + 8'd10);
                return 1'b1;
            end
            if (c >= "A" && c <= "F") begin
                nib = 4'(c - "A" + 8'd10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Input ran out inside a \u escape: the characters taken so far are
        // decoded again as plain text, where a further \u is dropped with its u.
        function void replay_held(input int k);
            int i;
            i = 0;
            while (i < k) begin
                if (held[i] == CH_BSL && i + 1 < k) begin
                    if (held[i+1] != CH_U) push_content(unescape_char(held[i+1]));
                    i += 2;
                end else if (held[i] == CH_QUOTE) begin
                    push_done(ST_QUOTE);
                    return;
                end else begin
                    push_content(held[i]);
                    i += 1;
                end
            end
            push_done(ST_RAN_OUT);
        endfunction

        function void note_input(input logic [7:0] c, input logic f, input logic l);
            logic [3:0]  nib;
            logic [15:0] cp;
            int          k;
            // A byte marked first always starts over, whatever was in progress.
            if (f) begin
                if (c != CH_QUOTE) begin
                    push_done(ST_NO_QUOTE);
                    return;
                end
                mode = M_TEXT;
                if (l) push_done(ST_RAN_OUT);
                return;
            end
            case (mode)
                M_TEXT: begin
                    if (c == CH_BSL) begin
                        if (l) begin
                            push_content(c);
                            push_done(ST_RAN_OUT);
                        end else begin
                            mode = M_ESC;
                        end
                    end else if (c == CH_QUOTE) begin
                        push_done(ST_QUOTE);
                    end else begin
                        push_content(c);
                        if (l) push_done(ST_RAN_OUT);
                    end
                end
                M_ESC: begin
                    if (c == CH_U) begin
                        mode = M_HEX;
                        clear_hex();
                    end else begin
                        push_content(unescape_char(c));
                        mode = M_TEXT;
                    end
                    if (l) push_done(ST_RAN_OUT);
                end
                M_HEX: begin
                    // Every character after \u is consumed; only a leading run of
                    // hex digits contributes to the code point.
                    if (digits_taken < 3'd3) held[digits_taken] = c;
                    if (prefix_open && decode_hex_digit(c, nib)) begin
                        code_point = {code_point[11:0], nib};
                    end else begin
                        prefix_open = 1'b0;
                    end
                    digits_taken = digits_taken + 3'd1;
                    if (digits_taken >= 3'd4) begin
                        cp = code_point;
                        if (decode_hex_digit(held[0], nib)) begin
                            if (cp < UTF8_LIM1) begin
                                push_content(cp[7:0]);
                            end else if (cp < UTF8_LIM2) begin
                                push_content(UTF8_LEAD2 | cp[13:6]);
                                push_content(UTF8_CONT | {2'b00, cp[5:0]});
                            end else begin
                                push_content(UTF8_LEAD3 | {4'h0, cp[15:12]});
                                push_content(UTF8_CONT | {2'b00, cp[11:6]});
                                push_content(UTF8_CONT | {2'b00, cp[5:0]});
                            end
                        end
                        mode = M_TEXT;
                        clear_hex();
                        if (l) push_done(ST_RAN_OUT);
                    end else if (l) begin
                        k = int'(digits_taken);
                        clear_hex();
                        replay_held(k);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(input logic [7:0] b, input logic v, input logic d,
                                   input logic [1:0] s);
            t_result want;
            if (decoded_q.size() == 0) begin
                $error("unexpected result: out_byte %02h byte_valid %0b done_res %0b status %0d",
                       b, v, d, s);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (b !== want.data) begin
                $error("out_byte: expected %02h, actual %02h", want.data, b);
                errors++;
            end
            if (v !== want.valid) begin
                $error("byte_valid: expected %0b, actual %0b", want.valid, v);
                errors++;
            end
            if (d !== want.done) begin
                $error("done_res: expected %0b, actual %0b", want.done, d);
                errors++;
            end
            if (s !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, s);
                errors++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       in_first  = 1'b0;
    logic       in_last   = 1'b0;
    logic       out_stall = 1'b0;
    wire logic       in_stall;
    wire logic       out_valid;
    wire logic [7:0] out_byte;
    wire logic       byte_valid;
    wire logic       done_res;
    wire logic [1:0] status;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    t_text_item         line_q [$];
    unescape_scoreboard sb;

    always #5 clk = ~clk;

    json_string_unescaper dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_byte    (in_byte),
        .i_first      (in_first),
        .i_last       (in_last),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_byte   (out_byte),
        .o_byte_valid (byte_valid),
        .o_done_res   (done_res),
        .o_status     (status)
    );

    // The receiving side stalls at random at the rate of the current phase.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Both handshakes are observed at the clock edge; a long silence ends the run.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.note_input(in_byte, in_first, in_last);
            if (out_valid && !out_stall) begin
                sb.check_result(out_byte, byte_valid, done_res, status);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one byte, idling first at the sender's rate, and hold it until taken.
    task automatic send_item(input t_text_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= it.text;
        in_first <= it.first;
        in_last  <= it.last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic add_item(input logic [7:0] b, input logic f, input logic l);
        t_text_item it;
        it.text  = b;
        it.first = f;
        it.last  = l;
        line_q.push_back(it);
    endtask

    task automatic flush_line();
        foreach (line_q[i]) send_item(line_q[i]);
        items_sent += line_q.size();
        line_q.delete();
    endtask

    // Hold the input off until the block has delivered everything it owes.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE || c == CH_BSL) c = c ^ 8'h01;
        return c;
    endfunction

    function automatic logic [7:0] escape_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0: c = "n";
            1: c = "r";
            2: c = "t";
            3: c = "b";
            4: c = "f";
            5: c = "/";
            6: c = CH_BSL;
            7: c = CH_QUOTE;
            default: begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_U) c = "v";
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input int v, input bit upper);
        if (v < 10) return 8'("0" + v);
        return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    // A \u escape; leading zeros reach the one- and two-byte encodings, and
    // some escapes carry junk that cuts the digit run short.
    task automatic add_unicode();
        int         shape;
        logic [7:0] c;
        shape = $urandom_range(0, 3);
        add_item(CH_BSL, 1'b0, 1'b0);
        add_item(CH_U, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++) begin
            if ((shape == 0 && i < 2) || (shape == 1 && i == 0)) begin
                c = "0";
            end else if (shape == 3 && $urandom_range(0, 2) == 0) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                c = hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1)));
            end
            add_item(c, 1'b0, 1'b0);
        end
    endtask

    // One string value: mostly well formed, sometimes cut short by the end of
    // the input, sometimes abandoned by the next opener, sometimes no opener at all.
    task automatic build_random_string(output bit left_open);
        int         ending;
        int         cut;
        int         kind;
        logic [7:0] c;
        t_text_item it;
        left_open = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_QUOTE) c = 8'h27;
            add_item(c, 1'b1, 1'($urandom_range(0, 1)));
            return;
        end
        add_item(CH_QUOTE, 1'b1, 1'b0);
        repeat ($urandom_range(0, 6)) begin
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                add_item(plain_byte(), 1'b0, 1'b0);
            end else if (kind <= 6) begin
                add_item(CH_BSL, 1'b0, 1'b0);
                add_item(escape_char(), 1'b0, 1'b0);
            end else begin
                add_unicode();
            end
        end
        ending = $urandom_range(0, 9);
        if (ending <= 5) begin
            add_item(CH_QUOTE, 1'b0, 1'($urandom_range(0, 3) == 0));
        end else if (ending <= 8) begin
            cut = $urandom_range(0, line_q.size() - 1);
            while (line_q.size() > cut + 1) void'(line_q.pop_back());
            it = line_q[cut];
            it.last = 1'b1;
            line_q[cut] = it;
        end else begin
            left_open = 1'b1;
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_rate, input int count);
        int         target;
        bit         left_open;
        t_text_item it;
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        target        = items_sent + count;
        while (items_sent < target) begin
            build_random_string(left_open);
            flush_line();
            // A stray byte between strings, which the block drops.
            if (!left_open && $urandom_range(0, 4) == 0) begin
                it.text  = 8'($urandom_range(0, 255));
                it.first = 1'b0;
                it.last  = 1'($urandom_range(0, 1));
                send_item(it);
            end
            // A byte with random markers anywhere in the flow.
            if ($urandom_range(0, 14) == 0) begin
                add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
                flush_line();
            end
        end
        wait_for_results();
    endtask

    initial begin
        t_text_item it;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 12;
        stall_pct     = 80;

        // Opener that is not a quote, at the lowest byte value.
        add_item(8'h00, 1'b1, 1'b0);
        flush_line();
        // Byte outside any string at the highest value; dropped.
        it.text  = 8'hFF;
        it.first = 1'b0;
        it.last  = 1'b0;
        send_item(it);
        // Opening quote that is also the end of the input.
        add_item(CH_QUOTE, 1'b1, 1'b1);
        // Backslash as the last byte.
        add_item(CH_QUOTE, 1'b1, 1'b0);
        add_item(CH_BSL, 1'b0, 1'b1);
        // Escaped character as the last byte.
        add_item(CH_QUOTE, 1'b1, 1'b0);
        add_item(CH_BSL, 1'b0, 1'b0);
        add_item("n", 1'b0, 1'b1);
        // A u that ends the input.
        add_item(CH_QUOTE, 1'b1, 1'b0);
        add_item(CH_BSL, 1'b0, 1'b0);
        add_item(CH_U, 1'b0, 1'b1);
        // Short \u at the end: the held quote closes the replayed text.
        add_item(CH_QUOTE, 1'b1, 1'b0);
        add_item(CH_BSL, 1'b0, 1'b0);
        add_item(CH_U, 1'b0, 1'b0);
        add_item("A", 1'b0, 1'b0);
        add_item(CH_QUOTE, 1'b0, 1'b1);
        // Largest code point, then a new opener abandons the string.
        add_item(CH_QUOTE, 1'b1, 1'b0);
        add_item(CH_BSL, 1'b0, 1'b0);
        add_item(CH_U, 1'b0, 1'b0);
        repeat (4) add_item("F", 1'b0, 1'b0);
        add_item(CH_QUOTE, 1'b1, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0);
        add_item(CH_QUOTE, 1'b0, 1'b0);
        flush_line();
        wait_for_results();

        run_random_phase(12, 80, PHASE_ITEMS);
        run_random_phase(80, 12, PHASE_ITEMS);
        run_random_phase(0, 0, PHASE_ITEMS);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescaper.sv
verif/testbench.sv
